### rtl/core/parabolic_sine_cosine_top_assert.svh
// ----------------------------------------------------------------------------
// Parabolic sine/cosine: assertion macros
// Shared concurrent-assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PARABOLIC_SINE_COSINE_TOP_ASSERT_SVH
`define PARABOLIC_SINE_COSINE_TOP_ASSERT_SVH

// Whenever pre holds, post must hold in the same cycle.
`define PSC_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("psc: condition violated");

// Whenever cond holds, sig keeps its value into the next cycle.
`define PSC_ASSERT_HOLD(label, cond, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("psc: held value changed");

`endif

### rtl/core/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Constants of the parabolic sine/cosine approximation: angle constants in
// Q16, scaled polynomial coefficients and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package psc_pkg;

  localparam int ANGLE_WIDTH_DEF      = 24;
  localparam int RESULT_FRAC_BITS_DEF = 16;

  // Restoring-reduction steps performed in each pipeline stage.
  localparam int RED_BITS_PER_STAGE = 4;

  localparam logic [17:0] PI_Q16      = 18'd205887;
  localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
  localparam logic [16:0] HALF_PI_Q16 = 17'd102944;

  // 4/pi in Q32 is 2^32 plus this remainder.
  localparam logic [30:0] FOUR_PI_LO  = 31'd1173554890;
  // 4/pi^2 in Q24.
  localparam logic [22:0] FOUR_PI_SQ  = 23'd6799550;
  // 0.775 and 0.225 in Q30.
  localparam logic [29:0] K775        = 30'd832149094;
  localparam logic [27:0] K225        = 28'd241591910;

endpackage

`default_nettype wire

### rtl/core/parabolic_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// parabolic_sine_cosine_top
// Sine or cosine of a Q8.16 angle by the corrected parabola approximation.
// Input request: in_kind (0 sine, 1 cosine) and in_angle, taken when in_valid
// is high and in_stall low. Result request: out_value, signed Q1.16 at the
// defaults, offered on out_valid until out_stall is low.
// One request is accepted every cycle unless in_stall is high. The pipeline
// starts with RED_STAGES = ceil((ANGLE_WIDTH - 18) / 4) (at least one)
// stages, the depth of the modulo-2*pi reduction, four restoring steps per
// stage. The twelve other stages are the wrap, the multiplier stages of
// the parabola and correction, and the output register.
// The pipeline advances as a whole: while a result waits under out_stall,
// every stage holds and in_stall is high. Reset empties the pipeline; no
// results are pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module parabolic_sine_cosine_top #(
  parameter int ANGLE_WIDTH      = psc_pkg::ANGLE_WIDTH_DEF,
  parameter int RESULT_FRAC_BITS = psc_pkg::RESULT_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic                                 in_kind,
  input  wire logic signed [ANGLE_WIDTH-1:0]        in_angle,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [RESULT_FRAC_BITS+1:0]   out_value
);

  localparam int OUT_W      = RESULT_FRAC_BITS + 2;
  localparam int REM_W      = 19;
  localparam int BPS        = psc_pkg::RED_BITS_PER_STAGE;
  localparam int RED_TOP    = (ANGLE_WIDTH < 18) ? ANGLE_WIDTH : 18;
  localparam int RED_STEPS  = ANGLE_WIDTH - RED_TOP;
  localparam int RED_STAGES = (RED_STEPS == 0) ? 1 : (RED_STEPS + BPS - 1) / BPS;
  localparam int LOW_W      = (RED_STEPS == 0) ? 1 : RED_STEPS;
  localparam int T_W        = 21;
  localparam int A_W        = 18;
  localparam int NSTAGE     = RED_STAGES + 11;

  localparam int ST_W2 = RED_STAGES + 1;

  // The angle is offset by 2^(W-1) to make it unsigned; this undoes it.
  localparam logic [63:0] OFFSET_MOD =
    (64'd1 << (ANGLE_WIDTH - 1)) % 64'(psc_pkg::TWO_PI_Q16);

  localparam logic [REM_W:0]       TWO_PI_X  = (REM_W + 1)'(psc_pkg::TWO_PI_Q16);
  localparam logic signed [T_W-1:0] OFF_S    = T_W'(OFFSET_MOD);
  localparam logic signed [T_W-1:0] HALF_S   = T_W'(psc_pkg::HALF_PI_Q16);
  localparam logic signed [T_W-1:0] PI_S     = T_W'(psc_pkg::PI_Q16);
  localparam logic signed [T_W-1:0] NEG_PI_S = -PI_S;
  localparam logic signed [T_W-1:0] TWO_PI_S = T_W'(psc_pkg::TWO_PI_Q16);
  localparam logic signed [OUT_W-1:0] VAL_MAX = OUT_W'(1) << RESULT_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] VAL_MIN = -VAL_MAX;

  logic                   adv;
  logic [NSTAGE-1:0]      pipe_vld_r;
  logic                   out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;

  // Reduction stages.
  logic [ANGLE_WIDTH-1:0] ang_u;
  logic [REM_W-1:0]       red_rem_in;
  logic [LOW_W-1:0]       red_low_in;
  logic [REM_W-1:0]       red_rem_r   [RED_STAGES];
  logic [REM_W-1:0]       red_rem_nxt [RED_STAGES];
  logic [LOW_W-1:0]       red_low_r   [RED_STAGES];
  logic [LOW_W-1:0]       red_low_nxt [RED_STAGES];
  logic                   red_kind_r  [RED_STAGES];
  logic                   red_kind_nxt[RED_STAGES];

  // Wrap stages.
  logic signed [T_W-1:0]  w1_t_r, w1_t_nxt;
  logic signed [T_W-1:0]  w2_wrap;
  logic [T_W-1:0]         w2_abs;
  logic [A_W-1:0]         w2_a_r;
  logic                   w2_neg_r;

  // Arithmetic stages.
  logic [A_W-1:0] m1_a_r;
  logic [48:0]    m1_p1_r;
  logic [35:0]    m1_sq_r;
  logic [51:0]    m2_t1_r;
  logic [40:0]    m2_ph_r, m2_pl_r;
  logic [51:0]    m3_t1_r, m3_t2_r;
  logic [59:0]    m3_sum;
  logic [51:0]    m4_diff;
  logic [49:0]    m4_m48_r;
  logic [50:0]    m5_sum;
  logic [30:0]    m5_m30_r;
  logic [61:0]    m6_sqm_r;
  logic [60:0]    m6_p775_r;
  logic [62:0]    m7_sum;
  logic [30:0]    m7_s30_r;
  logic [60:0]    m7_p775_r;
  logic [58:0]    m8_p225_r;
  logic [60:0]    m8_p775_r;
  logic [61:0]    m9_res_r;
  logic [62:0]    out_sum;
  logic [OUT_W-1:0] out_mag;
  logic [8:0]     neg_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign ang_u      = {~in_angle[ANGLE_WIDTH-1], in_angle[ANGLE_WIDTH-2:0]};
  assign red_rem_in = REM_W'(ang_u[ANGLE_WIDTH-1 -: RED_TOP]);

  generate
    if (RED_STEPS > 0) begin : g_low
      assign red_low_in = ang_u[LOW_W-1:0];
    end else begin : g_nolow
      assign red_low_in = 1'b0;
    end
  endgenerate

  // Restoring reduction modulo 2*pi: the remainder stays below 2*pi, so one
  // conditional subtraction per shifted-in bit suffices.
  always_comb begin
    logic [REM_W:0]   acc;
    logic [LOW_W-1:0] low_sh;
    for (int j = 0; j < RED_STAGES; j++) begin
      if (j == 0) begin
        acc             = {1'b0, red_rem_in};
        low_sh          = red_low_in;
        red_kind_nxt[j] = in_kind;
      end else begin
        acc             = {1'b0, red_rem_r[j-1]};
        low_sh          = red_low_r[j-1];
        red_kind_nxt[j] = red_kind_r[j-1];
      end
      for (int k = 0; k < BPS; k++) begin
        if (j * BPS + k < RED_STEPS) begin
          acc    = {acc[REM_W-1:0], low_sh[LOW_W-1]};
          low_sh = low_sh << 1;
          if (acc >= TWO_PI_X) begin
            acc = acc - TWO_PI_X;
          end
        end
      end
      red_rem_nxt[j] = acc[REM_W-1:0];
      red_low_nxt[j] = low_sh;
    end
  end

  // Remove the unsigned offset and add pi/2 for cosine in one sum.
  assign w1_t_nxt = $signed({2'b00, red_rem_r[RED_STAGES-1]}) - OFF_S
                    + (red_kind_r[RED_STAGES-1] ? HALF_S : T_W'(0));

  // The sum lies between -2*pi and 5*pi/2; one correction brings it into -pi..pi.
  always_comb begin
    if (w1_t_r > PI_S) begin
      w2_wrap = w1_t_r - TWO_PI_S;
    end else if (w1_t_r < NEG_PI_S) begin
      w2_wrap = w1_t_r + TWO_PI_S;
    end else begin
      w2_wrap = w1_t_r;
    end
    w2_abs = w2_wrap[T_W-1] ? T_W'(-w2_wrap) : T_W'(w2_wrap);
  end

  assign m3_sum  = 60'({m2_ph_r, 18'd0}) + 60'(m2_pl_r) + 60'd128;
  assign m4_diff = m3_t1_r - m3_t2_r;
  assign m5_sum  = 51'(m4_m48_r) + (51'd1 << 17);
  assign m7_sum  = 63'(m6_sqm_r) + (63'd1 << 29);
  assign out_sum = 63'(m9_res_r) + (63'd1 << (59 - RESULT_FRAC_BITS));
  assign out_mag = out_sum[60 - RESULT_FRAC_BITS +: OUT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pipe_vld_r  <= {pipe_vld_r[NSTAGE-2:0], in_valid};
      out_valid_r <= pipe_vld_r[NSTAGE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < RED_STAGES; j++) begin
        red_rem_r[j]  <= red_rem_nxt[j];
        red_low_r[j]  <= red_low_nxt[j];
        red_kind_r[j] <= red_kind_nxt[j];
      end
      w1_t_r    <= w1_t_nxt;
      w2_a_r    <= w2_abs[A_W-1:0];
      w2_neg_r  <= w2_wrap[T_W-1];
      // Parabola 4/pi*a - 4/pi^2*a*a on the magnitude.
      m1_a_r    <= w2_a_r;
      m1_p1_r   <= 49'(w2_a_r) * 49'(psc_pkg::FOUR_PI_LO);
      m1_sq_r   <= 36'(w2_a_r) * 36'(w2_a_r);
      m2_t1_r   <= 52'({m1_a_r, 32'd0}) + 52'(m1_p1_r);
      m2_ph_r   <= 41'(m1_sq_r[35:18]) * 41'(psc_pkg::FOUR_PI_SQ);
      m2_pl_r   <= 41'(m1_sq_r[17:0]) * 41'(psc_pkg::FOUR_PI_SQ);
      m3_t1_r   <= m2_t1_r;
      m3_t2_r   <= m3_sum[59:8];
      // Rounding can push the square term past the linear one near pi.
      m4_m48_r  <= (m3_t1_r > m3_t2_r) ? m4_diff[49:0] : 50'd0;
      m5_m30_r  <= m5_sum[48:18];
      // Correction 0.775*y + 0.225*y*|y|.
      m6_sqm_r  <= 62'(m5_m30_r) * 62'(m5_m30_r);
      m6_p775_r <= 61'(m5_m30_r) * 61'(psc_pkg::K775);
      m7_s30_r  <= m7_sum[60:30];
      m7_p775_r <= m6_p775_r;
      m8_p225_r <= 59'(m7_s30_r) * 59'(psc_pkg::K225);
      m8_p775_r <= m7_p775_r;
      m9_res_r  <= 62'(m8_p775_r) + 62'(m8_p225_r);
      neg_r     <= {neg_r[7:0], w2_neg_r};
      out_value_r <= neg_r[8] ? $signed(-out_mag) : $signed(out_mag);
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`include "parabolic_sine_cosine_top_assert.svh"

  `PSC_ASSERT_HOLD(a_stall_holds_pipe, in_stall, pipe_vld_r)
  `PSC_ASSERT_IMPLY(a_wrap_in_range, pipe_vld_r[ST_W2], w2_a_r <= psc_pkg::PI_Q16)
  `PSC_ASSERT_IMPLY(a_out_in_range, out_valid_r, (out_value_r <= VAL_MAX) && (out_value_r >= VAL_MIN))

endmodule

`default_nettype wire
